// ===== sv/sldu10_pkg.sv =====
// ---------------------------------------------------------------------------
// sldu10_pkg
// shared types and constants of the raw10 line deframer / unpacker
// ---------------------------------------------------------------------------
package sldu10_pkg;

	// one input transfer: a byte of the frame stream and its framing marks
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       frame_end;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic [7:0] pixel;
		logic       line_last;
		logic       discard_line;
	} out_item_t;

	// configuration register file contents
	typedef struct packed {
		logic [39:0] line_magic;
		logic [14:0] line_length;
		logic [13:0] video_offset;
		logic [13:0] pix_width;
	} cfg_t;

	// classified work item passed from front to back
	typedef struct packed {
		logic       discard;
		logic       last;
		logic [2:0] phase;
		logic [7:0] cur_byte;
		logic [7:0] prev_byte;
	} cmd_t;

	// register indexes (byte address = 8 * index)
	localparam logic [1:0] REG_LINE_MAGIC   = 2'd0;
	localparam logic [1:0] REG_LINE_LENGTH  = 2'd1;
	localparam logic [1:0] REG_VIDEO_OFFSET = 2'd2;
	localparam logic [1:0] REG_PIX_WIDTH    = 2'd3;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 64;

	// reset values of the registers
	localparam logic [39:0] RST_LINE_MAGIC   = 40'd0;
	localparam logic [14:0] RST_LINE_LENGTH  = 15'd16384;
	localparam logic [13:0] RST_VIDEO_OFFSET = 14'd16;
	localparam logic [13:0] RST_PIX_WIDTH    = 14'd4096;

	// byte position inside a five-byte raw10 group
	localparam logic [2:0] PH_B0 = 3'd0;
	localparam logic [2:0] PH_B1 = 3'd1;
	localparam logic [2:0] PH_B2 = 3'd2;
	localparam logic [2:0] PH_B3 = 3'd3;
	localparam logic [2:0] PH_B4 = 3'd4;

	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned MIN_LINE_BYTES = 8;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ===== sv/sldu10_cfg.sv =====
// ---------------------------------------------------------------------------
// sldu10_cfg
// apb register file holding the deframer configuration
// ---------------------------------------------------------------------------
module sldu10_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sldu10_pkg::ADDR_W-1:0]       paddr,
	input  logic [sldu10_pkg::DATA_W-1:0]       pwdata,
	output logic [sldu10_pkg::DATA_W-1:0]       prdata,
	output logic                                pready,
	output sldu10_pkg::cfg_t                    cfg
);

	sldu10_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[sldu10_pkg::ADDR_W-1:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_magic   <= sldu10_pkg::RST_LINE_MAGIC;
			cfg_q.line_length  <= sldu10_pkg::RST_LINE_LENGTH;
			cfg_q.video_offset <= sldu10_pkg::RST_VIDEO_OFFSET;
			cfg_q.pix_width    <= sldu10_pkg::RST_PIX_WIDTH;
		end else if (wr_en) begin
			case (reg_idx)
				sldu10_pkg::REG_LINE_MAGIC:   cfg_q.line_magic   <= pwdata[39:0];
				sldu10_pkg::REG_LINE_LENGTH:  cfg_q.line_length  <= pwdata[14:0];
				sldu10_pkg::REG_VIDEO_OFFSET: cfg_q.video_offset <= pwdata[13:0];
				sldu10_pkg::REG_PIX_WIDTH:    cfg_q.pix_width    <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sldu10_pkg::REG_LINE_MAGIC:   prdata = {24'd0, cfg_q.line_magic};
			sldu10_pkg::REG_LINE_LENGTH:  prdata = {49'd0, cfg_q.line_length};
			sldu10_pkg::REG_VIDEO_OFFSET: prdata = {50'd0, cfg_q.video_offset};
			sldu10_pkg::REG_PIX_WIDTH:    prdata = {50'd0, cfg_q.pix_width};
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== sv/sldu10_front.sv =====
// ---------------------------------------------------------------------------
// sldu10_front
// line tracking, header check, pixel classification, one byte per fire cycle
// ---------------------------------------------------------------------------
module sldu10_front #(
	parameter int unsigned MAX_LINE_BYTES = 16384,
	parameter int unsigned MAX_WIDTH      = 8192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sldu10_pkg::cfg_t     cfg,
	input  logic                 fire,
	input  sldu10_pkg::in_item_t sample,
	output logic                 cmd_valid,
	output sldu10_pkg::cmd_t     cmd
);

	localparam int unsigned POS_W  = $clog2(MAX_LINE_BYTES);
	localparam int unsigned LEN_W  = ($clog2(MAX_LINE_BYTES + 1) > 15) ?
	                                 $clog2(MAX_LINE_BYTES + 1) : 15;
	localparam int unsigned PC_W   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WW     = (PC_W > 14) ? PC_W : 14;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(sldu10_pkg::MIN_LINE_BYTES);
	localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(sldu10_pkg::HEADER_BYTES);
	localparam logic [WW-1:0]    WID_MAX = WW'(MAX_WIDTH);

	logic [POS_W-1:0] pos_q;
	logic             hdr_q;
	logic [2:0]       phase_q;
	logic [PC_W-1:0]  cnt_q;
	logic [7:0]       prev_q;

	logic [LEN_W-1:0] len_raw, len_eff, pos_ext, vstart;
	logic [WW-1:0]    wid_raw, wid_clamp, width4, cnt_inc_ext;
	logic [POS_W-1:0] pos_cur;
	logic             hdr_cur, hdr_next, match;
	logic [2:0]       phase_cur, phase_next;
	logic [PC_W-1:0]  cnt_cur, cnt_inc;
	logic [7:0]       magic_byte;
	logic             in_header, last_byte, video, emit, discard, line_done;

	always_comb begin
		// effective register values after clamping
		len_raw = LEN_W'(cfg.line_length);
		if (len_raw < LEN_MIN)      len_eff = LEN_MIN;
		else if (len_raw > LEN_MAX) len_eff = LEN_MAX;
		else                        len_eff = len_raw;
		vstart = (cfg.video_offset < 14'(sldu10_pkg::HEADER_BYTES)) ?
		         HDR_LEN : LEN_W'(cfg.video_offset);
		wid_raw   = WW'(cfg.pix_width);
		wid_clamp = (wid_raw > WID_MAX) ? WID_MAX : wid_raw;
		width4    = {wid_clamp[WW-1:2], 2'b00};

		// frame start restarts the line before the byte is handled
		pos_cur   = sample.frame_start ? '0 : pos_q;
		hdr_cur   = sample.frame_start ? 1'b0 : hdr_q;
		phase_cur = sample.frame_start ? sldu10_pkg::PH_B0 : phase_q;
		cnt_cur   = sample.frame_start ? '0 : cnt_q;
		pos_ext   = LEN_W'(pos_cur);

		last_byte = pos_ext >= (len_eff - LEN_W'(1));
		in_header = pos_ext < HDR_LEN;

		case (pos_cur[2:0])
			3'd0:    magic_byte = cfg.line_magic[39:32];
			3'd1:    magic_byte = cfg.line_magic[31:24];
			3'd2:    magic_byte = cfg.line_magic[23:16];
			3'd3:    magic_byte = cfg.line_magic[15:8];
			3'd4:    magic_byte = cfg.line_magic[7:0];
			default: magic_byte = 8'd0;
		endcase
		match = (sample.data_byte == magic_byte);

		if (!in_header)        hdr_next = hdr_cur;
		else if (pos_cur == '0) hdr_next = match;
		else                   hdr_next = hdr_cur & match;

		cnt_inc     = cnt_cur + PC_W'(1);
		cnt_inc_ext = WW'(cnt_inc);
		video = !in_header && hdr_cur && (pos_ext >= vstart) && (WW'(cnt_cur) < width4);
		emit  = video && (phase_cur != sldu10_pkg::PH_B1);
		if (!video)                            phase_next = phase_cur;
		else if (phase_cur >= sldu10_pkg::PH_B4) phase_next = sldu10_pkg::PH_B0;
		else                                   phase_next = phase_cur + 3'd1;

		discard   = (sample.frame_start && (pos_q != '0)) ||
		            (sample.frame_end && !last_byte);
		line_done = last_byte || sample.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= 1'b0;
			phase_q <= sldu10_pkg::PH_B0;
			cnt_q   <= '0;
			prev_q  <= 8'd0;
		end else if (fire) begin
			prev_q <= sample.data_byte;
			if (line_done) begin
				pos_q   <= '0;
				hdr_q   <= 1'b0;
				phase_q <= sldu10_pkg::PH_B0;
				cnt_q   <= '0;
			end else begin
				pos_q   <= pos_cur + POS_W'(1);
				hdr_q   <= hdr_next;
				phase_q <= phase_next;
				cnt_q   <= emit ? cnt_inc : cnt_cur;
			end
		end
	end

	assign cmd_valid     = fire && (discard || emit);
	assign cmd.discard   = discard;
	assign cmd.last      = emit && (cnt_inc_ext == width4);
	assign cmd.phase     = phase_cur;
	assign cmd.cur_byte  = sample.data_byte;
	assign cmd.prev_byte = prev_q;

endmodule

// ===== sv/sldu10_queue.sv =====
// ---------------------------------------------------------------------------
// sldu10_queue
// short fifo decoupling the classifier from the unpack/output stage
// ---------------------------------------------------------------------------
module sldu10_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  sldu10_pkg::cmd_t wr_cmd,
	output logic             full,
	input  logic             rd_en,
	output logic             nonempty,
	output sldu10_pkg::cmd_t rd_cmd
);

	localparam int unsigned DEPTH = sldu10_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sldu10_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && nonempty;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)      count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== sv/sldu10_back.sv =====
// ---------------------------------------------------------------------------
// sldu10_back
// pixel extraction from raw10 groups and the result output register
// ---------------------------------------------------------------------------
module sldu10_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  sldu10_pkg::cmd_t      cmd,
	output logic                  cmd_take,
	output logic                  empty,
	input  logic                  pop,
	output sldu10_pkg::out_item_t result
);

	sldu10_pkg::out_item_t res_q, res_d;
	logic                  valid_q;

	always_comb begin
		case (cmd.phase)
			sldu10_pkg::PH_B0: res_d.pixel = cmd.cur_byte;
			sldu10_pkg::PH_B2: res_d.pixel = {cmd.prev_byte[5:0], cmd.cur_byte[7:6]};
			sldu10_pkg::PH_B3: res_d.pixel = {cmd.prev_byte[3:0], cmd.cur_byte[7:4]};
			sldu10_pkg::PH_B4: res_d.pixel = {cmd.prev_byte[1:0], cmd.cur_byte[7:2]};
			default:           res_d.pixel = 8'd0;
		endcase
		res_d.line_last    = cmd.last;
		res_d.discard_line = 1'b0;
		if (cmd.discard) begin
			res_d.pixel        = 8'd0;
			res_d.line_last    = 1'b0;
			res_d.discard_line = 1'b1;
		end
	end

	// load when the output register is free or drains this cycle
	assign cmd_take = cmd_valid && (!valid_q || pop);
	assign empty    = !valid_q;
	assign result   = res_q;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/sensor_line_deframe_unpack10.sv =====
// ---------------------------------------------------------------------------
// sensor_line_deframe_unpack10
// raw10 sensor line deframer: checks line headers, unpacks packed video
// into 8-bit pixels and flags the last pixel of each line
// ---------------------------------------------------------------------------
//
// channel   handshake            payload                              
// input     push / full          sample : data_byte, frame_start, frame_end
// result    empty / pop          result : pixel, line_last, discard_line
// config    psel/penable/pwrite  paddr[4:3] register, pwdata / prdata 64 bit
//
// one byte is taken every cycle while full is low; each byte gives zero or
// one result, so the sustained rate is one byte per clock while pop keeps up
// a result is registered first in the queue, which the classifier writes,
// and then in the output register
// full rises only when the four-entry queue and the output register are both
// occupied, i.e. when the consumer holds off pop
// no clearing pass after reset; the block takes bytes from the first cycle
//
module sensor_line_deframe_unpack10 #(
	parameter int unsigned MAX_LINE_BYTES = 16384,
	parameter int unsigned MAX_WIDTH      = 8192
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte stream in
	input  logic                                push,
	output logic                                full,
	input  sldu10_pkg::in_item_t                sample,
	// pixels out
	output logic                                empty,
	input  logic                                pop,
	output sldu10_pkg::out_item_t               result,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sldu10_pkg::ADDR_W-1:0]       paddr,
	input  logic [sldu10_pkg::DATA_W-1:0]       pwdata,
	output logic [sldu10_pkg::DATA_W-1:0]       prdata,
	output logic                                pready
);

	sldu10_pkg::cfg_t cfg;
	sldu10_pkg::cmd_t front_cmd, queue_cmd;
	logic             fire;
	logic             front_valid;
	logic             queue_nonempty;
	logic             back_take;

	// an input transfer completes whenever the queue has room
	assign fire = push && !full;

	// configuration registers
	sldu10_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: line position, header match, group phase and pixel count
	sldu10_front #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES),
		.MAX_WIDTH      (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.sample    (sample),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	// decoupling queue; its full flag is what the producer sees
	sldu10_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (back_take),
		.nonempty (queue_nonempty),
		.rd_cmd   (queue_cmd)
	);

	// back: bit extraction and the output register
	sldu10_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_nonempty),
		.cmd       (queue_cmd),
		.cmd_take  (back_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
